// File: design/itr_pkg.sv
// shared types, constants and helpers of the ir touch relay controller
`timescale 1ns / 1ps

package itr_pkg;

    // tally depth default, range 1 to 15
    localparam int VOTE_DEPTH_DEF = 10;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LEADER     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ONE_BIT    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESS      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RELEASE    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_IDLE       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_CODE = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_POWER_CODE = 3'd6;

    // register reset values
    localparam logic [7:0]  LEADER_RST     = 8'd60;
    localparam logic [7:0]  ONE_BIT_RST    = 8'd5;
    localparam logic [11:0] PRESS_RST      = 12'd500;
    localparam logic [11:0] RELEASE_RST    = 12'd2000;
    localparam logic [11:0] IDLE_RST       = 12'd1800;
    localparam logic [7:0]  LEVEL_CODE_RST = 8'hBB;
    localparam logic [7:0]  POWER_CODE_RST = 8'h1B;

    // counter ceilings
    localparam logic [7:0]  GAP_MAX = 8'hF0;
    localparam logic [11:0] CNT_MAX = 12'hFFF;

    localparam logic [3:0] BITS_PER_FRAME = 4'd8;

    typedef struct packed {
        logic mode;
        logic touch_level;
    } item_t;

    typedef struct packed {
        logic       relay_one;
        logic       relay_two;
        logic       power_on;
        logic [1:0] level;
        logic       frame_done;
        logic [7:0] frame_code;
    } result_t;

    typedef struct packed {
        logic [7:0]  leader_ticks;
        logic [7:0]  one_bit_ticks;
        logic [11:0] press_ticks;
        logic [11:0] release_ticks;
        logic [11:0] idle_ticks;
        logic [7:0]  level_code;
        logic [7:0]  power_code;
    } cfg_t;

    // frame receiver to controller
    typedef struct packed {
        logic       done;
        logic [7:0] code;
    } ir_evt_t;

    // controller state after the current request
    typedef struct packed {
        logic       power_on;
        logic [1:0] level;
    } ctl_stat_t;

    // level 0 or 3 goes to 1, else up by one
    function automatic logic [1:0] step_level(input logic [1:0] lvl);
        step_level = (lvl == 2'd3) ? 2'd1 : lvl + 2'd1;
    endfunction

endpackage

// File: design/itr_ir_rx.sv
// ir edge timing and lsb-first byte assembly
`timescale 1ns / 1ps

module itr_ir_rx
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          step,
    input  logic          mode,
    input  itr_pkg::cfg_t cfg,
    output itr_pkg::ir_evt_t evt
);
    import itr_pkg::*;

    logic       expect_falling_reg, expect_falling_next;
    logic       receiving_reg, receiving_next;
    logic [3:0] bit_index_reg, bit_index_next;
    logic [7:0] gap_counter_reg, gap_counter_next;
    logic [7:0] shift_byte_reg, shift_byte_next;
    logic       done;

    always_comb
    begin
        expect_falling_next = expect_falling_reg;
        receiving_next      = receiving_reg;
        bit_index_next      = bit_index_reg;
        gap_counter_next    = gap_counter_reg;
        shift_byte_next     = shift_byte_reg;
        done                = 1'b0;
        if (step)
        begin
            if (!mode)
            begin
                if (gap_counter_reg < GAP_MAX)
                    gap_counter_next = gap_counter_reg + 8'd1;
            end
            else if (expect_falling_reg)
            begin
                expect_falling_next = 1'b0;
                // long gap: leader, frame restarts
                if (gap_counter_reg > cfg.leader_ticks)
                begin
                    receiving_next = 1'b1;
                    bit_index_next = '0;
                end
                gap_counter_next = '0;
            end
            else
            begin
                expect_falling_next = 1'b1;
                if (receiving_reg)
                begin
                    shift_byte_next  = {gap_counter_reg > cfg.one_bit_ticks,
                                        shift_byte_reg[7:1]};
                    gap_counter_next = '0;
                    bit_index_next   = bit_index_reg + 4'd1;
                    if (bit_index_next >= BITS_PER_FRAME)
                    begin
                        done           = 1'b1;
                        receiving_next = 1'b0;
                        bit_index_next = '0;
                    end
                end
            end
        end
    end

    assign evt.done = done;
    assign evt.code = shift_byte_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expect_falling_reg <= 1'b1;
            receiving_reg      <= 1'b0;
            bit_index_reg      <= '0;
            gap_counter_reg    <= '0;
            shift_byte_reg     <= '0;
        end
        else
        begin
            expect_falling_reg <= expect_falling_next;
            receiving_reg      <= receiving_next;
            bit_index_reg      <= bit_index_next;
            gap_counter_reg    <= gap_counter_next;
            shift_byte_reg     <= shift_byte_next;
        end
    end

endmodule

// File: design/itr_ctrl.sv
// code tally, majority vote, touch debounce and power/level state
`timescale 1ns / 1ps

module itr_ctrl
#(
    parameter int VOTE_DEPTH = itr_pkg::VOTE_DEPTH_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,
    input  logic             mode,
    input  logic             touch_level,
    input  itr_pkg::ir_evt_t evt,
    input  itr_pkg::cfg_t    cfg,
    output itr_pkg::ctl_stat_t stat
);
    import itr_pkg::*;

    localparam logic [3:0] VOTE_LIMIT = 4'(VOTE_DEPTH);

    logic [3:0]  code_total_reg, code_total_next;
    logic [3:0]  level_votes_reg, level_votes_next;
    logic [3:0]  power_votes_reg, power_votes_next;
    logic        vote_pending_reg, vote_pending_next;
    logic [11:0] idle_counter_reg, idle_counter_next;
    logic [11:0] touch_counter_reg, touch_counter_next;
    logic        touch_active_reg, touch_active_next;
    logic        touch_seen_reg, touch_seen_next;
    logic        power_state_reg, power_state_next;
    logic [1:0]  level_state_reg, level_state_next;
    logic [3:0]  half;
    logic        pressed;

    always_comb
    begin
        code_total_next    = code_total_reg;
        level_votes_next   = level_votes_reg;
        power_votes_next   = power_votes_reg;
        vote_pending_next  = vote_pending_reg;
        idle_counter_next  = idle_counter_reg;
        touch_counter_next = touch_counter_reg;
        touch_active_next  = touch_active_reg;
        touch_seen_next    = touch_seen_reg;
        power_state_next   = power_state_reg;
        level_state_next   = level_state_reg;
        half               = code_total_reg >> 1;
        pressed            = 1'b0;
        if (step)
        begin
            if (!mode)
            begin
                if (touch_counter_reg != CNT_MAX)
                    touch_counter_next = touch_counter_reg + 12'd1;
                if (idle_counter_reg != CNT_MAX)
                    idle_counter_next = idle_counter_reg + 12'd1;
            end

            // tally or vote
            if (evt.done)
            begin
                idle_counter_next = '0;
                vote_pending_next = 1'b1;
                if (evt.code == cfg.level_code)
                    level_votes_next = level_votes_reg + 4'd1;
                else if (evt.code == cfg.power_code)
                    power_votes_next = power_votes_reg + 4'd1;
                code_total_next = code_total_reg + 4'd1;
                if (code_total_next >= VOTE_LIMIT)
                begin
                    code_total_next  = '0;
                    level_votes_next = '0;
                    power_votes_next = '0;
                end
            end
            else if (vote_pending_reg && idle_counter_next > cfg.idle_ticks)
            begin
                vote_pending_next = 1'b0;
                if (level_votes_reg > half)
                begin
                    if (power_state_reg)
                        level_state_next = step_level(level_state_reg);
                end
                else if (power_votes_reg > half)
                begin
                    power_state_next = !power_state_reg;
                    level_state_next = power_state_reg ? 2'd0 : 2'd1;
                end
                code_total_next  = '0;
                level_votes_next = '0;
                power_votes_next = '0;
            end

            // touch debounce, counter low while touched
            if (!touch_level)
            begin
                if (touch_active_reg)
                    touch_counter_next = '0;
                else if (touch_counter_next > cfg.press_ticks)
                begin
                    touch_counter_next = '0;
                    touch_active_next  = 1'b1;
                    pressed            = 1'b1;
                end
            end
            else
            begin
                if (touch_active_reg)
                begin
                    if (touch_counter_next > cfg.release_ticks)
                    begin
                        touch_counter_next = '0;
                        touch_active_next  = 1'b0;
                    end
                end
                else
                    touch_counter_next = '0;
            end

            if (pressed)
                power_state_next = 1'b1;
            if (touch_active_next)
            begin
                if (!touch_seen_reg)
                begin
                    touch_seen_next  = 1'b1;
                    level_state_next = step_level(level_state_next);
                end
            end
            else
                touch_seen_next = 1'b0;
        end
    end

    assign stat.power_on = power_state_next;
    assign stat.level    = level_state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            code_total_reg    <= '0;
            level_votes_reg   <= '0;
            power_votes_reg   <= '0;
            vote_pending_reg  <= 1'b0;
            idle_counter_reg  <= '0;
            touch_counter_reg <= '0;
            touch_active_reg  <= 1'b0;
            touch_seen_reg    <= 1'b0;
            power_state_reg   <= 1'b0;
            level_state_reg   <= '0;
        end
        else
        begin
            code_total_reg    <= code_total_next;
            level_votes_reg   <= level_votes_next;
            power_votes_reg   <= power_votes_next;
            vote_pending_reg  <= vote_pending_next;
            idle_counter_reg  <= idle_counter_next;
            touch_counter_reg <= touch_counter_next;
            touch_active_reg  <= touch_active_next;
            touch_seen_reg    <= touch_seen_next;
            power_state_reg   <= power_state_next;
            level_state_reg   <= level_state_next;
        end
    end

endmodule

// File: design/itr_out_buf.sv
// result register with one skid entry
`timescale 1ns / 1ps

module itr_out_buf
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  itr_pkg::result_t push_data,
    output logic             full,
    output logic             result_valid,
    input  logic             result_stall,
    output itr_pkg::result_t result_data
);
    import itr_pkg::*;

    logic    main_valid_reg, main_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t main_reg, main_next;
    result_t skid_reg, skid_next;
    logic    pop;

    assign pop = main_valid_reg && !result_stall;

    always_comb
    begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_next       = main_reg;
        skid_next       = skid_reg;
        if (pop)
        begin
            if (skid_valid_reg)
            begin
                main_next       = skid_reg;
                skid_valid_next = 1'b0;
            end
            else if (push)
                main_next = push_data;
            else
                main_valid_next = 1'b0;
        end
        else if (push)
        begin
            if (!main_valid_reg)
            begin
                main_next       = push_data;
                main_valid_next = 1'b1;
            end
            else
            begin
                skid_next       = push_data;
                skid_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

    assign full         = skid_valid_reg;
    assign result_valid = main_valid_reg;
    assign result_data  = main_reg;

endmodule

// File: design/ir_touch_relay_controller.sv
// top level of the ir touch relay controller
`timescale 1ns / 1ps
// usage
// - item channel (item_valid / item_stall / item_data): each request is a
//   timer tick (mode 0) or an ir receiver edge (mode 1), with the sampled
//   active-low touch level; edges alternate falling, rising
// - result channel (result_valid / result_stall / result_data): exactly one
//   result per request, in order: relay drives, power flag, level, frame
//   done flag and the current byte of the ir shifter
// - cfg port: cfg_we writes cfg_data into register cfg_index at the clock
//   edge; write only while no request is in flight
// - output: each result is registered at the edge that takes its request
// - throughput: one request per cycle while item_stall is low; the frame
//   receiver, tally/vote and touch debounce are all combinational ahead
//   of the result register
// - stall: a result register plus one skid entry; item_stall rises only
//   once both hold results, so one extra request is taken after a stall
// - reset: all counters and tallies clear, power off, level 0, receiver
//   waits for a falling edge, registers return to their defaults; no
//   results are pending
module ir_touch_relay_controller
#(
    parameter int VOTE_DEPTH = itr_pkg::VOTE_DEPTH_DEF
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            item_valid,
    output logic                            item_stall,
    input  itr_pkg::item_t                  item_data,
    output logic                            result_valid,
    input  logic                            result_stall,
    output itr_pkg::result_t                result_data,
    input  logic                            cfg_we,
    input  logic [itr_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [itr_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import itr_pkg::*;

    cfg_t      cfg_reg, cfg_next;
    logic      step;        // request taken this cycle
    ir_evt_t   evt;
    ctl_stat_t stat;
    result_t   res;
    logic      buf_full;

    // register file, writes past the last index are dropped
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_LEADER:     cfg_next.leader_ticks  = cfg_data[7:0];
                CFG_ONE_BIT:    cfg_next.one_bit_ticks = cfg_data[7:0];
                CFG_PRESS:      cfg_next.press_ticks   = cfg_data;
                CFG_RELEASE:    cfg_next.release_ticks = cfg_data;
                CFG_IDLE:       cfg_next.idle_ticks    = cfg_data;
                CFG_LEVEL_CODE: cfg_next.level_code    = cfg_data[7:0];
                CFG_POWER_CODE: cfg_next.power_code    = cfg_data[7:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.leader_ticks  <= LEADER_RST;
            cfg_reg.one_bit_ticks <= ONE_BIT_RST;
            cfg_reg.press_ticks   <= PRESS_RST;
            cfg_reg.release_ticks <= RELEASE_RST;
            cfg_reg.idle_ticks    <= IDLE_RST;
            cfg_reg.level_code    <= LEVEL_CODE_RST;
            cfg_reg.power_code    <= POWER_CODE_RST;
        end
        else
            cfg_reg <= cfg_next;
    end

    // skid entry occupied means no room for another result
    assign item_stall = buf_full;
    assign step       = item_valid && !buf_full;

    // edge timing and byte assembly
    itr_ir_rx u_ir_rx
    (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (step),
        .mode  (item_data.mode),
        .cfg   (cfg_reg),
        .evt   (evt)
    );

    // tally, vote, touch and relay level
    itr_ctrl #(.VOTE_DEPTH(VOTE_DEPTH)) u_ctrl
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (step),
        .mode        (item_data.mode),
        .touch_level (item_data.touch_level),
        .evt         (evt),
        .cfg         (cfg_reg),
        .stat        (stat)
    );

    // result as seen after this request
    always_comb
    begin
        res.relay_one  = stat.level[0];
        res.relay_two  = stat.level[1];
        res.power_on   = stat.power_on;
        res.level      = stat.level;
        res.frame_done = evt.done;
        res.frame_code = evt.code;
    end

    itr_out_buf u_out_buf
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (step),
        .push_data    (res),
        .full         (buf_full),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_data  (result_data)
    );

endmodule

// File: design/itr_checker.sv
// port-level checks of the ir touch relay controller, bound to the top level
`timescale 1ns / 1ps

module itr_checker
(
    input logic                           clk,
    input logic                           rst_n,
    input logic                           item_valid,
    input logic                           item_stall,
    input logic                           result_valid,
    input logic                           result_stall,
    input itr_pkg::result_t               result_data
);
    import itr_pkg::*;

    // stalled result holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result_data))
        else $error("stalled result changed");

    // relays follow the level bits
    a_relay_map: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> result_data.relay_one == result_data.level[0]
                      && result_data.relay_two == result_data.level[1])
        else $error("relay drive does not match level");

    // power on exactly when a level is selected
    a_power_level: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> result_data.power_on == (result_data.level != 2'd0))
        else $error("power flag and level disagree");

    // input side only stalls with results waiting
    a_stall_backed: assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> result_valid)
        else $error("item stall without pending result");

    // a taken request always leaves a result behind
    a_request_answered: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall |=> result_valid)
        else $error("taken request left no result");

endmodule

bind ir_touch_relay_controller itr_checker u_itr_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_data  (result_data)
);
